// File: hw/rtl/shadow_volume_index_gen_defines.svh
// Assertion macros for the shadow volume index generator.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SHADOW_VOLUME_INDEX_GEN_DEFINES_SVH
`define SHADOW_VOLUME_INDEX_GEN_DEFINES_SVH

// same-cycle implication
`define SVIG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svig: same-cycle check failed");

// next-cycle implication
`define SVIG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svig: next-cycle check failed");

`endif

// File: hw/rtl/svig_pkg.sv
// Types and constants for the shadow volume index generator.
// No dependencies; imported by every module of the block.
package svig_pkg;

	localparam int IDX_BITS = 16;   // index wrap width, equal to VERT_W
	localparam int VERT_W   = 16;

	localparam logic [1:0] MODE_EDGE  = 2'd0;
	localparam logic [1:0] MODE_BACK  = 2'd1;
	localparam logic [1:0] MODE_FRONT = 2'd2;

	localparam logic [1:0] CFG_SKIP_SECOND = 2'd0;
	localparam logic [1:0] CFG_BACK_CAP    = 2'd1;
	localparam logic [1:0] CFG_FRONT_CAP   = 2'd2;
	localparam logic [1:0] CFG_FAN_MODE    = 2'd3;

	typedef struct packed {
		logic skip_second_side;
		logic back_cap_enable;
		logic front_cap_enable;
		logic fan_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              group_start;
		logic [VERT_W-1:0] vert_a;
		logic [VERT_W-1:0] vert_b;
		logic [VERT_W-1:0] vert_c;
		logic              facing_first;
		logic              facing_second;
		logic              lone_edge;
		logic [VERT_W-1:0] far_offset;
	} item_t;

	typedef struct packed {
		logic [VERT_W-1:0] idx0;
		logic [VERT_W-1:0] idx1;
		logic [VERT_W-1:0] idx2;
		logic              ovf;
	} tri_t;

	// up to three triangles of one item, tris[0] emitted first
	typedef struct packed {
		tri_t [2:0] tris;
		logic [1:0] count;
	} tri_set_t;

	typedef struct packed {
		logic              pending;
		logic [VERT_W-1:0] anchor;
	} fan_t;

endpackage

// File: hw/rtl/svig_decode.sv
// Triangle generation for one registered item: silhouette test, side,
// fan, dark-cap and light-cap triangles, plus next fan state. Uses svig_pkg.
module svig_decode import svig_pkg::*; (
	input  item_t    item,
	input  cfg_t     cfg,
	input  fan_t     fan,
	output tri_set_t set,
	output fan_t     fan_next
);

	typedef struct packed {
		logic              ovf;
		logic [VERT_W-1:0] idx;
	} far_t;

	function automatic far_t far_add(input logic [VERT_W-1:0] v, input logic [VERT_W-1:0] off);
		logic [IDX_BITS:0] s;
		far_t r;
		s = {{(IDX_BITS+1-VERT_W){1'b0}}, v} + {{(IDX_BITS+1-VERT_W){1'b0}}, off};
		r.ovf = s[IDX_BITS];
		r.idx = s[VERT_W-1:0];
		return r;
	endfunction

	logic              pend;
	logic              sil;
	logic [VERT_W-1:0] v0, v1;
	far_t              v0f, v1f, af, bf, cf;
	logic [1:0]        n;

	assign pend = item.group_start | fan.pending;
	assign sil  = item.lone_edge ? item.facing_first
	                             : (item.facing_first ^ item.facing_second);
	assign v0   = item.facing_first ? item.vert_a : item.vert_b;
	assign v1   = item.facing_first ? item.vert_b : item.vert_a;
	assign v0f  = far_add(v0, item.far_offset);
	assign v1f  = far_add(v1, item.far_offset);
	assign af   = far_add(item.vert_a, item.far_offset);
	assign bf   = far_add(item.vert_b, item.far_offset);
	assign cf   = far_add(item.vert_c, item.far_offset);

	always_comb begin
		set              = '0;
		n                = 2'd0;
		fan_next.pending = pend;
		fan_next.anchor  = fan.anchor;
		unique case (item.mode)
			MODE_EDGE: begin
				if (sil) begin
					set.tris[n] = '{idx0: v1, idx1: v0, idx2: v0f.idx, ovf: v0f.ovf};
					n = n + 2'd1;
					if (!cfg.skip_second_side) begin
						set.tris[n] = '{idx0: v0f.idx, idx1: v1f.idx, idx2: v1,
						                ovf: v0f.ovf | v1f.ovf};
						n = n + 2'd1;
					end
					if (cfg.fan_mode && cfg.back_cap_enable) begin
						if (pend) begin
							fan_next.anchor  = v0f.idx;
							fan_next.pending = 1'b0;
						end else begin
							set.tris[n] = '{idx0: fan.anchor, idx1: v1f.idx,
							                idx2: v0f.idx, ovf: v0f.ovf | v1f.ovf};
							n = n + 2'd1;
						end
					end
				end
			end
			MODE_BACK: begin
				if (!cfg.fan_mode && cfg.back_cap_enable && item.facing_first) begin
					set.tris[0] = '{idx0: bf.idx, idx1: af.idx, idx2: cf.idx,
					                ovf: af.ovf | bf.ovf | cf.ovf};
					n = 2'd1;
				end
			end
			MODE_FRONT: begin
				if (cfg.front_cap_enable && item.facing_first) begin
					set.tris[0] = '{idx0: item.vert_a, idx1: item.vert_b,
					                idx2: item.vert_c, ovf: 1'b0};
					n = 2'd1;
				end
			end
			default: begin
			end
		endcase
		set.count = n;
	end

endmodule

// File: hw/rtl/svig_emit.sv
// Result queue: holds the triangles of one item and shifts them out one per
// transaction on the output stream. Uses svig_pkg.
module svig_emit import svig_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  tri_set_t              set,
	output logic                  can_load,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [3*VERT_W-1:0]   m_axis_tdata,   // tri_idx0, tri_idx1, tri_idx2
	output logic                  m_axis_tuser,   // index_overflow
	output logic                  m_axis_tlast    // last_of_item
);

	tri_t [2:0] slot_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop      = m_axis_tvalid & m_axis_tready;
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && can_load) begin
			cnt_q <= set.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			slot_q <= set.tris;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {slot_q[0].idx2, slot_q[0].idx1, slot_q[0].idx0};
	assign m_axis_tuser  = slot_q[0].ovf;
	assign m_axis_tlast  = (cnt_q == 2'd1);

endmodule

// File: hw/rtl/shadow_volume_index_gen.sv
// Top level of the shadow volume index generator: input stage, config
// registers, fan state. Uses svig_pkg, svig_decode, svig_emit and the defines.
//
// Usage:
// - s_axis carries edge and triangle items (tuser = mode), m_axis carries
//   index triangles, one per transaction, tlast on the last one of an item.
// - cfg_we/cfg_idx/cfg_data write the four 1-bit control registers; write
//   only while the block is idle.
// - An item is registered in the input stage, then its triangles are
//   loaded into the result queue, whose head drives m_axis.
// - Throughput: one item per cycle while m_axis is ready, for items giving
//   at most one triangle; an item giving n triangles (at most three) holds
//   the result queue until all n are taken, as m_axis carries one per cycle.
// - Items that give no triangle pass the input stage without filling the queue.
// - Reset: queue and input stage empty, fan waits for its first silhouette
//   edge, anchor zero, registers to their defaults (fan, both caps on).
// - When m_axis stalls, the queue holds its triangles and the input stage
//   holds one more item; s_axis_tready drops once both are full.
`include "shadow_volume_index_gen_defines.svh"
module shadow_volume_index_gen import svig_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// group_start, vert_a, vert_b, vert_c, facing_first, facing_second,
	// lone_edge, far_offset, zero pad to 72 bits
	input  logic [71:0]         s_axis_tdata,
	input  logic [1:0]          s_axis_tuser,   // mode
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [3*VERT_W-1:0] m_axis_tdata,   // tri_idx0, tri_idx1, tri_idx2
	output logic                m_axis_tuser,   // index_overflow
	output logic                m_axis_tlast,   // last_of_item
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic                cfg_data
);

	cfg_t     cfg_q;
	item_t    item_in;
	item_t    item_s1;
	logic     vld_s1;
	fan_t     fan_q;
	fan_t     fan_next;
	tri_set_t set;
	logic     can_load;
	logic     adv;

	assign item_in.mode          = s_axis_tuser;
	assign item_in.group_start   = s_axis_tdata[0];
	assign item_in.vert_a        = s_axis_tdata[16:1];
	assign item_in.vert_b        = s_axis_tdata[32:17];
	assign item_in.vert_c        = s_axis_tdata[48:33];
	assign item_in.facing_first  = s_axis_tdata[49];
	assign item_in.facing_second = s_axis_tdata[50];
	assign item_in.lone_edge     = s_axis_tdata[51];
	assign item_in.far_offset    = s_axis_tdata[67:52];

	assign adv           = vld_s1 & can_load;
	assign s_axis_tready = ~vld_s1 | can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{skip_second_side: 1'b0, back_cap_enable: 1'b1,
			           front_cap_enable: 1'b1, fan_mode: 1'b1};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SKIP_SECOND: cfg_q.skip_second_side <= cfg_data;
				CFG_BACK_CAP:    cfg_q.back_cap_enable  <= cfg_data;
				CFG_FRONT_CAP:   cfg_q.front_cap_enable <= cfg_data;
				CFG_FAN_MODE:    cfg_q.fan_mode         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (can_load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_q <= '{pending: 1'b1, anchor: '0};
		end else if (adv) begin
			fan_q <= fan_next;
		end
	end

	svig_decode u_decode (
		.item     (item_s1),
		.cfg      (cfg_q),
		.fan      (fan_q),
		.set      (set),
		.fan_next (fan_next)
	);

	svig_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (vld_s1),
		.set           (set),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a new item's triangles only enter once the queue has drained
	`SVIG_ASSERT_NOW(a_load_when_drained, adv, !m_axis_tvalid || (m_axis_tlast && m_axis_tready))
	// an item with triangles shows its first one next cycle
	`SVIG_ASSERT_NEXT(a_load_shows, adv && (set.count != 2'd0), m_axis_tvalid)
	// the fan only leaves pending on a consumed item
	`SVIG_ASSERT_NEXT(a_fan_arm, !adv && fan_q.pending, fan_q.pending)

endmodule
